### sv/fpss_pkg.sv
package fpss_pkg;

   localparam int MAX_COLS_DEFAULT    = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 4;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int ROW_W       = 16;
   localparam int COL_CFG_W   = 11;
   localparam int COL_INDEX_W = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_ROW_COUNT    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMN_COUNT = 1'd1;

   localparam logic [ROW_W-1:0]     ROW_COUNT_RESET    = 16'd64;
   localparam logic [COL_CFG_W-1:0] COLUMN_COUNT_RESET = 11'd64;

   typedef struct packed {
      logic inner;
      logic pass;
      logic border;
   } fpss_flags_type;

   localparam int FLAGS_W = $bits(fpss_flags_type);

endpackage

### sv/fpss_front.sv
module fpss_front #(
   parameter int MAX_COLS    = fpss_pkg::MAX_COLS_DEFAULT,
   parameter int SAMPLE_BITS = fpss_pkg::SAMPLE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = fpss_pkg::QUEUE_DEPTH,
   localparam int COL_W      = $clog2(MAX_COLS),
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
   localparam int REQ_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [fpss_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fpss_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [REQ_W-1:0]                     req_tdata,
   input  logic [CNT_W-1:0]                     queue_count,
   output logic                                 push,
   output fpss_pkg::fpss_flags_type             item_flags,
   output logic [fpss_pkg::ROW_W-1:0]           item_row,
   output logic [COL_W-1:0]                     item_col,
   output logic signed [SAMPLE_BITS-1:0]        item_cur,
   output logic signed [SAMPLE_BITS-1:0]        item_old,
   output logic signed [SAMPLE_BITS-1:0]        item_right,
   output logic signed [SAMPLE_BITS-1:0]        item_up,
   output logic signed [SAMPLE_BITS-1:0]        item_left
);

   localparam int CMP_W = COL_W + fpss_pkg::COL_CFG_W + 1;
   localparam int ROW_W = fpss_pkg::ROW_W;

   logic [ROW_W-1:0]                 rows_ff;
   logic [fpss_pkg::COL_CFG_W-1:0]   cols_ff;
   logic [ROW_W-1:0]                 row_ff;
   logic [COL_W-1:0]                 col_ff;

   logic signed [SAMPLE_BITS-1:0] line_prev  [MAX_COLS];
   logic signed [SAMPLE_BITS-1:0] line_prev2 [MAX_COLS];

   logic                          wr2_pend_ff;
   logic [COL_W-1:0]              wr2_addr_ff;

   logic                          a_v_ff;
   fpss_pkg::fpss_flags_type      a_flags_ff;
   logic [ROW_W-1:0]              a_row_ff;
   logic [COL_W-1:0]              a_col_ff;
   logic signed [SAMPLE_BITS-1:0] a_cur_ff;
   logic signed [SAMPLE_BITS-1:0] a_old_ff;
   logic signed [SAMPLE_BITS-1:0] a_right_ff;
   logic signed [SAMPLE_BITS-1:0] a_up_ff;
   logic signed [SAMPLE_BITS-1:0] a_left_ff;

   logic                          accept;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [ROW_W:0]                rows_eff;
   logic [CMP_W-1:0]              cols_raw;
   logic [CMP_W-1:0]              cols_eff;
   logic                          last_col;
   logic                          last_row;
   logic [COL_W-1:0]              col_right;
   logic [CNT_W:0]                used;
   fpss_pkg::fpss_flags_type      flags_in;
   logic [ROW_W-1:0]              row_in;
   logic [COL_W-1:0]              col_in;

   always_comb begin
      used       = (CNT_W + 1)'(queue_count) + (CNT_W + 1)'(a_v_ff);
      req_tready = (used < (CNT_W + 1)'(QUEUE_DEPTH));
      accept     = req_tvalid && req_tready;
      sample     = req_tdata[SAMPLE_BITS-1:0];

      rows_eff = (rows_ff == '0) ? (ROW_W + 1)'(1) : {1'b0, rows_ff};
      cols_raw = CMP_W'(cols_ff);
      if (cols_raw == '0) begin
         cols_eff = CMP_W'(1);
      end else if (cols_raw > CMP_W'(MAX_COLS)) begin
         cols_eff = CMP_W'(MAX_COLS);
      end else begin
         cols_eff = cols_raw;
      end

      last_col  = (CMP_W'(col_ff) + CMP_W'(1)) >= cols_eff;
      last_row  = ({1'b0, row_ff} + (ROW_W + 1)'(1)) >= rows_eff;
      col_right = col_ff + COL_W'(1);

      flags_in.inner  = row_ff >= ROW_W'(2);
      flags_in.pass   = (col_ff == '0) || last_col;
      flags_in.border = (row_ff == '0) || last_row;

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_right;
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= fpss_pkg::ROW_COUNT_RESET;
         cols_ff     <= fpss_pkg::COLUMN_COUNT_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         wr2_pend_ff <= 1'b0;
         a_v_ff      <= 1'b0;
         a_old_ff    <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               fpss_pkg::REG_ROW_COUNT: begin
                  rows_ff <= csr_wdata[ROW_W-1:0];
               end
               fpss_pkg::REG_COLUMN_COUNT: begin
                  cols_ff <= csr_wdata[fpss_pkg::COL_CFG_W-1:0];
               end
               default: begin
               end
            endcase
         end
         wr2_pend_ff <= accept;
         a_v_ff      <= accept && (flags_in.inner || flags_in.border);
         if (accept) begin
            row_ff   <= row_in;
            col_ff   <= col_in;
            a_old_ff <= line_prev[col_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_prev[col_ff] <= sample;
         wr2_addr_ff       <= col_ff;
         a_flags_ff        <= flags_in;
         a_row_ff          <= row_ff;
         a_col_ff          <= col_ff;
         a_cur_ff          <= sample;
         a_right_ff        <= line_prev[col_right];
         a_left_ff         <= a_old_ff;
         if (wr2_pend_ff && (wr2_addr_ff == col_ff)) begin
            a_up_ff <= a_old_ff;
         end else begin
            a_up_ff <= line_prev2[col_ff];
         end
      end
      if (wr2_pend_ff) begin
         line_prev2[wr2_addr_ff] <= a_old_ff;
      end
   end

   assign push       = a_v_ff;
   assign item_flags = a_flags_ff;
   assign item_row   = a_row_ff;
   assign item_col   = a_col_ff;
   assign item_cur   = a_cur_ff;
   assign item_old   = a_old_ff;
   assign item_right = a_right_ff;
   assign item_up    = a_up_ff;
   assign item_left  = a_left_ff;

endmodule

### sv/fpss_queue.sv
module fpss_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = fpss_pkg::QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data,
   output logic [CNT_W-1:0]  count
);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_pop;

   assign pop_valid = (count_ff != '0);
   assign do_pop    = pop && pop_valid;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (!push && do_pop) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/fpss_back.sv
module fpss_back #(
   parameter int MAX_COLS    = fpss_pkg::MAX_COLS_DEFAULT,
   parameter int SAMPLE_BITS = fpss_pkg::SAMPLE_BITS_DEFAULT,
   localparam int COL_W      = $clog2(MAX_COLS),
   localparam int RSP_W      = ((SAMPLE_BITS + fpss_pkg::ROW_W + fpss_pkg::COL_INDEX_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_pop,
   input  fpss_pkg::fpss_flags_type      item_flags,
   input  logic [fpss_pkg::ROW_W-1:0]    item_row,
   input  logic [COL_W-1:0]              item_col,
   input  logic signed [SAMPLE_BITS-1:0] item_cur,
   input  logic signed [SAMPLE_BITS-1:0] item_old,
   input  logic signed [SAMPLE_BITS-1:0] item_right,
   input  logic signed [SAMPLE_BITS-1:0] item_up,
   input  logic signed [SAMPLE_BITS-1:0] item_left,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int ROW_W = fpss_pkg::ROW_W;
   localparam int CIX_W = fpss_pkg::COL_INDEX_W;
   localparam int SUM_W = SAMPLE_BITS + 3;
   localparam int MAG_W = SAMPLE_BITS + 2;
   localparam int LO_W  = MAG_W / 2;
   localparam int HI_W  = MAG_W - LO_W;
   localparam int SH1   = HI_W + 3;
   localparam int X2_W  = LO_W + 3;
   localparam int SH2   = X2_W + 3;
   localparam logic [SH1-1:0] RECIP1 = SH1'((64'd1 << SH1) / 64'd5 + 64'd1);
   localparam logic [SH2-1:0] RECIP2 = SH2'((64'd1 << SH2) / 64'd5 + 64'd1);

   logic                          b1_v_ff, b2_v_ff, b3_v_ff;
   logic                          b3_inner_ff, b3_border_ff;
   fpss_pkg::fpss_flags_type      b1_flags_ff, b2_flags_ff;
   logic                          b1_neg_ff, b2_neg_ff, b3_neg_ff;
   logic                          b3_pass_ff;
   logic [ROW_W-1:0]              b1_row_ff, b2_row_ff, b3_row_ff;
   logic [COL_W-1:0]              b1_col_ff, b2_col_ff, b3_col_ff;
   logic signed [SAMPLE_BITS-1:0] b1_cur_ff, b2_cur_ff, b3_cur_ff;
   logic signed [SAMPLE_BITS-1:0] b1_old_ff, b2_old_ff, b3_old_ff;
   logic [MAG_W-1:0]              b1_mag_ff;
   logic [HI_W-1:0]               b2_h_ff, b2_qh_ff;
   logic [LO_W-1:0]               b2_l_ff;
   logic [MAG_W-1:0]              b3_q_ff;

   logic                          rsp_tvalid_ff;
   logic                          rsp_tlast_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff;
   logic [ROW_W-1:0]              rsp_row_ff;
   logic [CIX_W-1:0]              rsp_col_ff;

   logic                          out_free;
   logic                          b3_done;
   logic                          adv;
   logic signed [SUM_W-1:0]       sum;
   logic [SUM_W-1:0]              abs_sum;
   logic [SUM_W-1:0]              mag_wide;
   logic [HI_W+SH1-1:0]           prod1;
   logic [HI_W+2:0]               five_qh;
   logic [HI_W+2:0]               rem_hi;
   logic [X2_W-1:0]               x2;
   logic [X2_W+SH2-1:0]           prod2;
   logic [MAG_W-1:0]              q_signed;
   logic signed [SAMPLE_BITS-1:0] inner_value;
   logic [COL_W+CIX_W-1:0]        col_ext;

   always_comb begin
      out_free = !rsp_tvalid_ff || rsp_tready;
      b3_done  = out_free && b3_v_ff && !(b3_inner_ff && b3_border_ff);
      adv      = !b3_v_ff || b3_done;
      item_pop = adv && item_valid;

      sum = SUM_W'(item_left) + SUM_W'(item_old) + SUM_W'(item_right)
            + SUM_W'(item_up) + SUM_W'(item_cur);
      abs_sum  = sum[SUM_W-1] ? -sum : sum;
      mag_wide = abs_sum + SUM_W'(2);

      prod1 = (HI_W + SH1)'(b1_mag_ff[MAG_W-1:LO_W]) * (HI_W + SH1)'(RECIP1);

      five_qh = {b2_qh_ff, 2'b00} + (HI_W + 3)'(b2_qh_ff);
      rem_hi  = (HI_W + 3)'(b2_h_ff) - five_qh;
      x2      = {rem_hi[2:0], b2_l_ff};
      prod2   = (X2_W + SH2)'(x2) * (X2_W + SH2)'(RECIP2);

      q_signed    = b3_neg_ff ? -b3_q_ff : b3_q_ff;
      inner_value = b3_pass_ff ? b3_old_ff : q_signed[SAMPLE_BITS-1:0];
      col_ext     = {{CIX_W{1'b0}}, b3_col_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff       <= 1'b0;
         b2_v_ff       <= 1'b0;
         b3_v_ff       <= 1'b0;
         b3_inner_ff   <= 1'b0;
         b3_border_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (adv) begin
            b1_v_ff      <= item_pop;
            b2_v_ff      <= b1_v_ff;
            b3_v_ff      <= b2_v_ff;
            b3_inner_ff  <= b2_flags_ff.inner;
            b3_border_ff <= b2_flags_ff.border;
         end else if (out_free && b3_v_ff) begin
            b3_inner_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_tvalid_ff <= b3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_flags_ff <= item_flags;
         b1_neg_ff   <= sum[SUM_W-1];
         b1_mag_ff   <= mag_wide[MAG_W-1:0];
         b1_row_ff   <= item_row;
         b1_col_ff   <= item_col;
         b1_cur_ff   <= item_cur;
         b1_old_ff   <= item_old;

         b2_flags_ff <= b1_flags_ff;
         b2_neg_ff   <= b1_neg_ff;
         b2_h_ff     <= b1_mag_ff[MAG_W-1:LO_W];
         b2_l_ff     <= b1_mag_ff[LO_W-1:0];
         b2_qh_ff    <= prod1[HI_W+SH1-1:SH1];
         b2_row_ff   <= b1_row_ff;
         b2_col_ff   <= b1_col_ff;
         b2_cur_ff   <= b1_cur_ff;
         b2_old_ff   <= b1_old_ff;

         b3_pass_ff  <= b2_flags_ff.pass;
         b3_neg_ff   <= b2_neg_ff;
         b3_q_ff     <= {b2_qh_ff, prod2[SH2+LO_W-1:SH2]};
         b3_row_ff   <= b2_row_ff;
         b3_col_ff   <= b2_col_ff;
         b3_cur_ff   <= b2_cur_ff;
         b3_old_ff   <= b2_old_ff;
      end
      if (out_free && b3_v_ff) begin
         rsp_col_ff <= col_ext[CIX_W-1:0];
         if (b3_inner_ff) begin
            rsp_value_ff <= inner_value;
            rsp_row_ff   <= b3_row_ff - ROW_W'(1);
            rsp_tlast_ff <= !b3_border_ff;
         end else begin
            rsp_value_ff <= b3_cur_ff;
            rsp_row_ff   <= b3_row_ff;
            rsp_tlast_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = RSP_W'({rsp_col_ff, rsp_row_ff, rsp_value_ff});

endmodule

### sv/five_point_stencil_stream_unit.sv
// A result passes the front register, the queue, back stages b1 to b3 and the output register.
// Throughput: one sample per cycle, set by the line store access, while the queue has room;
// in the last row, from row 2 on, each sample makes two results, each its own output transfer.
// Reset: row and column counters clear, row_count and column_count load 64.
// The line stores are not cleared; no clearing pass runs after reset.
module five_point_stencil_stream_unit #(
   parameter int MAX_COLS    = fpss_pkg::MAX_COLS_DEFAULT,
   parameter int SAMPLE_BITS = fpss_pkg::SAMPLE_BITS_DEFAULT,
   localparam int REQ_W      = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W      = ((SAMPLE_BITS + fpss_pkg::ROW_W + fpss_pkg::COL_INDEX_W + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [fpss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpss_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_W-1:0]                 req_tdata,   // sample
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_W-1:0]                 rsp_tdata,   // value, row_index, col_index
   output logic                             rsp_tlast
);

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int DEPTH   = fpss_pkg::QUEUE_DEPTH;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ENTRY_W = fpss_pkg::FLAGS_W + fpss_pkg::ROW_W + COL_W + 5 * SAMPLE_BITS;

   logic                          push;
   fpss_pkg::fpss_flags_type      f_flags, b_flags;
   logic [fpss_pkg::ROW_W-1:0]    f_row, b_row;
   logic [COL_W-1:0]              f_col, b_col;
   logic signed [SAMPLE_BITS-1:0] f_cur, f_old, f_right, f_up, f_left;
   logic signed [SAMPLE_BITS-1:0] b_cur, b_old, b_right, b_up, b_left;
   logic [ENTRY_W-1:0]            push_data, pop_data;
   logic                          pop, pop_valid;
   logic [CNT_W-1:0]              queue_count;

   fpss_front #(
      .MAX_COLS    (MAX_COLS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .QUEUE_DEPTH (DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_count (queue_count),
      .push        (push),
      .item_flags  (f_flags),
      .item_row    (f_row),
      .item_col    (f_col),
      .item_cur    (f_cur),
      .item_old    (f_old),
      .item_right  (f_right),
      .item_up     (f_up),
      .item_left   (f_left)
   );

   assign push_data = {f_flags, f_row, f_col, f_cur, f_old, f_right, f_up, f_left};
   assign {b_flags, b_row, b_col, b_cur, b_old, b_right, b_up, b_left} = pop_data;

   fpss_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .count     (queue_count)
   );

   fpss_back #(
      .MAX_COLS    (MAX_COLS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_pop   (pop),
      .item_flags (b_flags),
      .item_row   (b_row),
      .item_col   (b_col),
      .item_cur   (b_cur),
      .item_old   (b_old),
      .item_right (b_right),
      .item_up    (b_up),
      .item_left  (b_left),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### sim/tb_top.sv
typedef struct {
   logic signed [31:0] value;
   logic [15:0]        row;
   logic [9:0]         col;
   logic               run_last;
} stencil_out_type;

class stencil_tracker_type;
   logic signed [31:0] line_prev  [fpss_pkg::MAX_COLS_DEFAULT];
   logic signed [31:0] line_prev2 [fpss_pkg::MAX_COLS_DEFAULT];
   logic signed [31:0] left_sample;
   int unsigned        row_pos;
   int unsigned        col_pos;
   logic [15:0]        row_count;
   logic [10:0]        column_count;
   stencil_out_type    pending_cells [$];
   int unsigned        failures;

   function new();
      row_count    = fpss_pkg::ROW_COUNT_RESET;
      column_count = fpss_pkg::COLUMN_COUNT_RESET;
      row_pos      = 0;
      col_pos      = 0;
      left_sample  = '0;
      failures     = 0;
      foreach (line_prev[i]) begin
         line_prev[i]  = '0;
         line_prev2[i] = '0;
      end
   endfunction

   function void load_reg(logic [fpss_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] wdata);
      if (idx == fpss_pkg::REG_ROW_COUNT) begin
         row_count = wdata;
      end else if (idx == fpss_pkg::REG_COLUMN_COUNT) begin
         column_count = wdata[10:0];
      end
   endfunction

   function int unsigned rows_eff();
      return (row_count == 0) ? 1 : row_count;
   endfunction

   function int unsigned cols_eff();
      int unsigned n;
      n = (column_count == 0) ? 1 : column_count;
      if (n > fpss_pkg::MAX_COLS_DEFAULT) n = fpss_pkg::MAX_COLS_DEFAULT;
      return n;
   endfunction

   function logic signed [31:0] mean_of_five(longint sum);
      longint unsigned mag;
      longint          q;
      mag = (sum < 0) ? -sum : sum;
      q   = longint'((mag + 2) / 5);
      return 32'((sum < 0) ? -q : q);
   endfunction

   function void take_sample(logic signed [31:0] sample);
      int unsigned        r;
      int unsigned        c;
      bit                 last_col;
      bit                 last_row;
      bit                 border_out;
      logic signed [31:0] old;
      longint             sum;
      stencil_out_type    item;
      r          = row_pos;
      c          = col_pos;
      last_col   = (c + 1 >= cols_eff());
      last_row   = (r + 1 >= rows_eff());
      border_out = (r == 0) || last_row;
      old        = line_prev[c];
      if (r >= 2) begin
         if (c == 0 || last_col) begin
            item.value = old;
         end else begin
            sum = longint'(left_sample) + longint'(old) + longint'(line_prev[c+1])
                + longint'(line_prev2[c]) + longint'(sample);
            item.value = mean_of_five(sum);
         end
         item.row      = 16'(r - 1);
         item.col      = 10'(c);
         item.run_last = !border_out;
         pending_cells.push_back(item);
      end
      if (border_out) begin
         item.value    = sample;
         item.row      = 16'(r);
         item.col      = 10'(c);
         item.run_last = 1'b1;
         pending_cells.push_back(item);
      end
      line_prev2[c] = old;
      line_prev[c]  = sample;
      left_sample   = old;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function void match_result(logic [63:0] tdata, logic tlast);
      stencil_out_type want;
      if (pending_cells.size() == 0) begin
         $error("unexpected result transfer: value %h row %0d col %0d",
                tdata[31:0], tdata[47:32], tdata[57:48]);
         failures++;
         return;
      end
      want = pending_cells.pop_front();
      if (tdata[31:0] !== want.value) begin
         $error("value: expected %h, got %h", want.value, tdata[31:0]);
         failures++;
      end
      if (tdata[47:32] !== want.row) begin
         $error("row_index: expected %0d, got %0d", want.row, tdata[47:32]);
         failures++;
      end
      if (tdata[57:48] !== want.col) begin
         $error("col_index: expected %0d, got %0d", want.col, tdata[57:48]);
         failures++;
      end
      if (tdata[63:58] !== 6'd0) begin
         $error("padding: expected %h, got %h", 6'd0, tdata[63:58]);
         failures++;
      end
      if (tlast !== want.run_last) begin
         $error("run_last: expected %0b, got %0b", want.run_last, tlast);
         failures++;
      end
   endfunction
endclass

module tb_top;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_TOGGLE} ready_mode_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             csr_wen    = 1'b0;
   logic [fpss_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [fpss_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [31:0]                      req_tdata  = '0;  // sample
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [63:0]                      rsp_tdata;        // value, row_index, col_index
   logic                             rsp_tlast;

   stencil_tracker_type grid = new();
   int unsigned         burst_left   = 1;
   int unsigned         samples_sent = 0;
   int unsigned         ready_run    = 0;
   ready_mode_type      ready_mode   = READY_ALWAYS;

   five_point_stencil_stream_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   initial begin
      #4800000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) grid.match_result(rsp_tdata, rsp_tlast);
         if (ready_run == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            ready_run  = $urandom_range(16, 160);
         end else begin
            ready_run--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return $urandom_range(0, 2000) - 1000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_sample(logic [31:0] s);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      grid.take_sample(s);
      samples_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 160)
                                                  : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // hold off until every expected transfer is back, then let the pipe empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (grid.pending_cells.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_csr(logic [fpss_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] wdata);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(posedge clock);
      grid.load_reg(idx, wdata);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic finish_frame();
      do begin
         send_sample(random_sample());
      end while (grid.row_pos != 0 || grid.col_pos != 0);
   endtask

   task automatic run_phase(logic [15:0] rows, logic [15:0] cols, int unsigned frames, bit cut);
      int unsigned size;
      int unsigned part;
      settle();
      set_csr(fpss_pkg::REG_ROW_COUNT, rows);
      set_csr(fpss_pkg::REG_COLUMN_COUNT, cols | (16'($urandom_range(0, 31)) << 11));
      repeat (frames) finish_frame();
      size = grid.rows_eff() * grid.cols_eff();
      if (cut && size > 1) begin
         part = (size - 1 < 8 * grid.cols_eff()) ? size - 1 : 8 * grid.cols_eff();
         repeat ($urandom_range(1, part)) send_sample(random_sample());
         settle();
         // lower a count to at most the running counter (or to 1) so the frame ends early
         if (grid.rows_eff() > 64 || $urandom_range(0, 1)) begin
            set_csr(fpss_pkg::REG_ROW_COUNT,
                    16'((grid.row_pos == 0) ? 1 : $urandom_range(1, grid.row_pos)));
         end else begin
            set_csr(fpss_pkg::REG_COLUMN_COUNT,
                    16'((grid.col_pos == 0) ? 1 : $urandom_range(1, grid.col_pos)));
         end
         finish_frame();
      end
   endtask

   function automatic logic [15:0] pick_rows();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'd2;
         default: return 16'($urandom_range(3, 7));
      endcase
   endfunction

   function automatic logic [15:0] pick_cols();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'd2;
         3:       return 16'($urandom_range(9, 24));
         default: return 16'($urandom_range(3, 8));
      endcase
   endfunction

   initial begin
      int unsigned base;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0000);
      settle();
      set_csr(fpss_pkg::REG_COLUMN_COUNT, 16'd3);
      set_csr(fpss_pkg::REG_ROW_COUNT, 16'd3);
      send_sample(32'hFFFF_FFFF);
      repeat (6) send_sample(32'h7FFF_FFFF);
      settle();
      repeat (9) send_sample(32'h8000_0000);
      settle();
      set_csr(fpss_pkg::REG_ROW_COUNT, 16'd0);
      set_csr(fpss_pkg::REG_COLUMN_COUNT, 16'd0);
      repeat (2) send_sample(random_sample());
      settle();
      set_csr(fpss_pkg::REG_ROW_COUNT, 16'd1);
      set_csr(fpss_pkg::REG_COLUMN_COUNT, 16'd4);
      repeat (4) send_sample(random_sample());

      run_phase(16'd1, 16'd2047, 1, 1'b0);
      run_phase(16'd1, 16'd1024, 1, 1'b0);
      run_phase(16'd65535, 16'($urandom_range(3, 6)), 0, 1'b1);

      base = samples_sent;
      while (samples_sent - base < 750) begin
         run_phase(pick_rows(), pick_cols(), $urandom_range(1, 3), $urandom_range(0, 3) == 0);
      end
      settle();

      if (grid.failures == 0 && grid.pending_cells.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
sv/fpss_pkg.sv
sv/fpss_front.sv
sv/fpss_queue.sv
sv/fpss_back.sv
sv/five_point_stencil_stream_unit.sv
sim/tb_top.sv
